// ===== design/apsc_pkg.sv =====
// Shared types and constants of the adaptive page size controller.
package apsc_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned DUR_W      = 32;
  localparam int unsigned PAGE_W     = 24;
  localparam int unsigned BOUND_W    = 24;
  localparam int unsigned THR_W      = 31;
  localparam int unsigned FACTOR_W   = 16;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  typedef logic [PAGE_W-1:0]   page_t;
  typedef logic [BOUND_W-1:0]  bound_t;
  typedef logic [THR_W-1:0]    thr_t;
  typedef logic [FACTOR_W-1:0] factor_t;
  typedef logic [FRAC_W-1:0]   frac_t;
  typedef logic [STEP_W-1:0]   step_t;

  typedef enum logic [OP_W-1:0] {
    OP_SUCCESS = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LIMIT = 3'd0,
    CFG_MAX_LIMIT = 3'd1,
    CFG_FAST_THR  = 3'd2,
    CFG_GROW_FAC  = 3'd3,
    CFG_SLOW_THR  = 3'd4,
    CFG_SHRINK    = 3'd5,
    CFG_TIMEOUT   = 3'd6,
    CFG_STEP      = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SETTLE,
    ST_ROUND,
    ST_DIV,
    ST_FINAL,
    ST_DONE
  } state_e;

  localparam bound_t  RST_MIN_LIMIT = 24'd1;
  localparam bound_t  RST_MAX_LIMIT = 24'hFFFFFF;
  localparam thr_t    RST_FAST_THR  = 31'd1000;
  localparam factor_t RST_GROW_FAC  = 16'd512;
  localparam thr_t    RST_SLOW_THR  = 31'd5000;
  localparam frac_t   RST_SHRINK    = 8'd230;
  localparam frac_t   RST_TIMEOUT   = 8'd128;
  localparam step_t   RST_STEP      = 16'd1;

endpackage

// ===== design/adaptive_page_size_controller_top.sv =====
// Top level of the adaptive page size controller.
// Keeps one page limit and scales it by Q8.8 factors on success and timeout
// items, or loads it on a restart item; every item returns one page_limit.
// One item is in flight at a time. A success item in neither duration band,
// or an unused operation code, goes straight to the done state. A scaling
// item runs the shift-add multiplier, then settles and rounds; a restart
// skips the multiplier. With a rounding step above one, rounding runs the
// one-bit-per-cycle remainder divider. A finished result waits in an output
// register while the next item is taken.
module adaptive_page_size_controller_top #(
  parameter int unsigned LIMIT_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [apsc_pkg::OP_W-1:0]           operation_i,
  input  logic signed [apsc_pkg::DUR_W-1:0]   duration_ms_i,
  input  logic [apsc_pkg::BOUND_W-1:0]        start_limit_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [apsc_pkg::PAGE_W-1:0]         page_limit_o,
  input  logic                                cfg_we_i,
  input  logic [apsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [apsc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned BND_W = (LIMIT_WIDTH > apsc_pkg::BOUND_W) ?
                                  LIMIT_WIDTH : apsc_pkg::BOUND_W;
  localparam int unsigned DIV_W = ((LIMIT_WIDTH > apsc_pkg::STEP_W) ?
                                  LIMIT_WIDTH : apsc_pkg::STEP_W) + 1;
  localparam int unsigned PROD_W = LIMIT_WIDTH + apsc_pkg::FACTOR_W;

  typedef logic [LIMIT_WIDTH-1:0] lim_t;

  localparam lim_t LimAll = '1;
  localparam lim_t LimOne = lim_t'(1);

  function automatic lim_t clamp_f(lim_t v, lim_t lo, lim_t hi);
    lim_t r;
    r = (v < lo) ? lo : v;
    r = (r > hi) ? hi : r;
    return r;
  endfunction

  // configuration registers
  apsc_pkg::bound_t  min_q, max_q;
  apsc_pkg::thr_t    fast_q, slow_q;
  apsc_pkg::factor_t grow_q;
  apsc_pkg::frac_t   shrink_q, timeout_q;
  apsc_pkg::step_t   step_q;

  apsc_pkg::state_e  state_q, state_d;
  lim_t              cur_q, v_q, lo_q, hi_q, lo_d, hi_d;
  logic [DIV_W-1:0]  num_q, num_d, rounded_w;
  lim_t              rounded;
  logic [BND_W-1:0]  min_w, max_w;
  logic              out_valid_q;
  apsc_pkg::page_t   out_q;

  logic              accept, out_fire, step_gt1;
  logic              neg, grow, shrink;
  apsc_pkg::factor_t factor;
  logic              mul_start, mul_done, div_start, div_done;
  logic [PROD_W-1:0] prod;
  lim_t              sat;
  apsc_pkg::step_t   div_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= apsc_pkg::RST_MIN_LIMIT;
      max_q     <= apsc_pkg::RST_MAX_LIMIT;
      fast_q    <= apsc_pkg::RST_FAST_THR;
      grow_q    <= apsc_pkg::RST_GROW_FAC;
      slow_q    <= apsc_pkg::RST_SLOW_THR;
      shrink_q  <= apsc_pkg::RST_SHRINK;
      timeout_q <= apsc_pkg::RST_TIMEOUT;
      step_q    <= apsc_pkg::RST_STEP;
    end else if (cfg_we_i) begin
      case (apsc_pkg::cfg_idx_e'(cfg_index_i))
        apsc_pkg::CFG_MIN_LIMIT: min_q     <= cfg_data_i[apsc_pkg::BOUND_W-1:0];
        apsc_pkg::CFG_MAX_LIMIT: max_q     <= cfg_data_i[apsc_pkg::BOUND_W-1:0];
        apsc_pkg::CFG_FAST_THR:  fast_q    <= cfg_data_i[apsc_pkg::THR_W-1:0];
        apsc_pkg::CFG_GROW_FAC:  grow_q    <= cfg_data_i[apsc_pkg::FACTOR_W-1:0];
        apsc_pkg::CFG_SLOW_THR:  slow_q    <= cfg_data_i[apsc_pkg::THR_W-1:0];
        apsc_pkg::CFG_SHRINK:    shrink_q  <= cfg_data_i[apsc_pkg::FRAC_W-1:0];
        apsc_pkg::CFG_TIMEOUT:   timeout_q <= cfg_data_i[apsc_pkg::FRAC_W-1:0];
        apsc_pkg::CFG_STEP:      step_q    <= cfg_data_i[apsc_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // bounds: zero reads as one, anything above the limit range saturates
  always_comb begin
    min_w = BND_W'(min_q);
    max_w = BND_W'(max_q);
    if (min_w == '0) begin
      lo_d = LimOne;
    end else if (min_w > BND_W'(LimAll)) begin
      lo_d = LimAll;
    end else begin
      lo_d = lim_t'(min_w);
    end
    if (max_w == '0) begin
      hi_d = LimOne;
    end else if (max_w > BND_W'(LimAll)) begin
      hi_d = LimAll;
    end else begin
      hi_d = lim_t'(max_w);
    end
  end

  assign step_gt1 = step_q > apsc_pkg::step_t'(1);
  assign accept   = in_valid_i && (state_q == apsc_pkg::ST_IDLE);
  assign out_fire = (state_q == apsc_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  // a negative duration falls in neither band
  assign neg    = duration_ms_i[apsc_pkg::DUR_W-1];
  assign grow   = !neg && (duration_ms_i[apsc_pkg::DUR_W-2:0] < fast_q);
  assign shrink = !neg && (duration_ms_i[apsc_pkg::DUR_W-2:0] > slow_q);

  always_comb begin
    if (apsc_pkg::op_e'(operation_i) == apsc_pkg::OP_TIMEOUT) begin
      factor = apsc_pkg::factor_t'(timeout_q);
    end else if (grow) begin
      factor = grow_q;
    end else begin
      factor = apsc_pkg::factor_t'(shrink_q);
    end
  end

  // drop the fraction, saturate at the top of the range
  always_comb begin
    if (prod[PROD_W-1:LIMIT_WIDTH+apsc_pkg::FRAC_W] != '0) begin
      sat = LimAll;
    end else begin
      sat = prod[LIMIT_WIDTH+apsc_pkg::FRAC_W-1:apsc_pkg::FRAC_W];
    end
  end

  // nearest multiple: (v + step/2) minus the remainder of dividing it by step
  assign num_d     = DIV_W'(v_q) + DIV_W'(step_q >> 1);
  assign rounded_w = num_q - DIV_W'(div_rem);
  always_comb begin
    if (rounded_w == '0) begin
      rounded = LimOne;
    end else if (rounded_w > DIV_W'(LimAll)) begin
      rounded = LimAll;
    end else begin
      rounded = lim_t'(rounded_w);
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state_q)
      apsc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (apsc_pkg::op_e'(operation_i))
            apsc_pkg::OP_SUCCESS: begin
              if (grow || shrink) begin
                mul_start = 1'b1;
                state_d   = apsc_pkg::ST_MUL;
              end else begin
                state_d = apsc_pkg::ST_DONE;
              end
            end
            apsc_pkg::OP_TIMEOUT: begin
              mul_start = 1'b1;
              state_d   = apsc_pkg::ST_MUL;
            end
            apsc_pkg::OP_RESTART: state_d = apsc_pkg::ST_SETTLE;
            default:              state_d = apsc_pkg::ST_DONE;
          endcase
        end
      end
      apsc_pkg::ST_MUL: begin
        if (mul_done) begin
          state_d = apsc_pkg::ST_SETTLE;
        end
      end
      apsc_pkg::ST_SETTLE: state_d = apsc_pkg::ST_ROUND;
      apsc_pkg::ST_ROUND: begin
        if (step_gt1) begin
          div_start = 1'b1;
          state_d   = apsc_pkg::ST_DIV;
        end else begin
          state_d = apsc_pkg::ST_DONE;
        end
      end
      apsc_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = apsc_pkg::ST_FINAL;
        end
      end
      apsc_pkg::ST_FINAL: state_d = apsc_pkg::ST_DONE;
      apsc_pkg::ST_DONE: begin
        if (out_fire) begin
          state_d = apsc_pkg::ST_IDLE;
        end
      end
      default: state_d = apsc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= LimOne;
      lo_q        <= LimOne;
      hi_q        <= LimAll;
      out_valid_q <= 1'b0;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
      if (state_q == apsc_pkg::ST_ROUND && !step_gt1) begin
        cur_q <= v_q;
      end else if (state_q == apsc_pkg::ST_FINAL) begin
        cur_q <= clamp_f(v_q, lo_q, hi_q);
      end
      if (out_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q <= lim_t'(start_limit_i);
    end else if (state_q == apsc_pkg::ST_MUL && mul_done) begin
      v_q <= sat;
    end else if (state_q == apsc_pkg::ST_SETTLE) begin
      v_q <= clamp_f(v_q, lo_q, hi_q);
    end else if (state_q == apsc_pkg::ST_DIV && div_done) begin
      v_q <= rounded;
    end
    if (div_start) begin
      num_q <= num_d;
    end
    if (out_fire) begin
      out_q <= apsc_pkg::page_t'(cur_q);
    end
  end

  apsc_mul #(
    .AW (LIMIT_WIDTH)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (cur_q),
    .b_i     (factor),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  apsc_div #(
    .DW (DIV_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_d),
    .den_i   (step_q),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  assign in_stall_o   = state_q != apsc_pkg::ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign page_limit_o = out_q;

  a_limit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q != '0)
    else $error("page limit reached zero");

  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == apsc_pkg::ST_MUL)
    else $error("multiplier finished outside its state");

  a_rem_below_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> div_rem < step_q)
    else $error("remainder not below the step");

  a_final_within_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == apsc_pkg::ST_FINAL |=> cur_q <= hi_q)
    else $error("rounded limit above the maximum");

endmodule

// ===== design/apsc_mul.sv =====
// Serial shift-add multiplier: one multiplier bit per cycle.
module apsc_mul #(
  parameter int unsigned AW = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [AW-1:0]                     a_i,
  input  logic [apsc_pkg::FACTOR_W-1:0]     b_i,
  output logic                              done_o,
  output logic [AW+apsc_pkg::FACTOR_W-1:0]  prod_o
);

  localparam int unsigned BW    = apsc_pkg::FACTOR_W;
  localparam int unsigned CNT_W = $clog2(BW);

  logic             run_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [AW-1:0]    a_q;
  logic [AW+BW-1:0] p_q;
  logic [AW:0]      sum;
  logic [AW+BW-1:0] p_d;

  always_comb begin
    if (p_q[0]) begin
      sum = {1'b0, p_q[AW+BW-1:BW]} + {1'b0, a_q};
    end else begin
      sum = {1'b0, p_q[AW+BW-1:BW]};
    end
    p_d = {sum, p_q[BW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(BW - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{AW{1'b0}}, b_i};
    end else if (run_q) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

// ===== design/apsc_div.sv =====
// Restoring divider that yields the remainder, one dividend bit per cycle.
module apsc_div #(
  parameter int unsigned DW = 25
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [DW-1:0]                   num_i,
  input  logic [apsc_pkg::STEP_W-1:0]     den_i,
  output logic                            done_o,
  output logic [apsc_pkg::STEP_W-1:0]     rem_o
);

  localparam int unsigned SW    = apsc_pkg::STEP_W;
  localparam int unsigned CNT_W = $clog2(DW);

  logic             run_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    num_q;
  logic [SW-1:0]    den_q;
  logic [SW-1:0]    rem_q;
  logic [SW:0]      trial;
  logic [SW:0]      diff;
  logic [SW-1:0]    rem_d;

  always_comb begin
    trial = {rem_q, num_q[DW-1]};
    diff  = trial - {1'b0, den_q};
    if (trial >= {1'b0, den_q}) begin
      rem_d = diff[SW-1:0];
    end else begin
      rem_d = trial[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(DW - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[DW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== dv/tb_adaptive_page_size_controller_top.sv =====
// Testbench of the adaptive page size controller: directed and random items, scoreboard check.
module tb_adaptive_page_size_controller_top;

  localparam int unsigned CLK_HALF     = 4;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned SETTLE_CYC   = 64;
  localparam int unsigned RAND_PHASES  = 10;
  localparam int unsigned PHASE_ITEMS  = 55;
  localparam longint unsigned RUN_LIMIT = 2000000;
  localparam logic [apsc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // Predicts the page limit after each item and holds the limits still owed by the block.
  class page_limit_scoreboard;
    localparam logic [63:0] LIMIT_MAX = 64'hFFFFFF;

    apsc_pkg::bound_t  min_reg;
    apsc_pkg::bound_t  max_reg;
    apsc_pkg::thr_t    fast_thr;
    apsc_pkg::factor_t grow;
    apsc_pkg::thr_t    slow_thr;
    apsc_pkg::frac_t   shrink;
    apsc_pkg::frac_t   tmo;
    apsc_pkg::step_t   step;
    apsc_pkg::page_t   limit;
    apsc_pkg::page_t   owed_q[$];
    int unsigned errors;
    int unsigned compared;

    function new();
      min_reg  = apsc_pkg::RST_MIN_LIMIT;
      max_reg  = apsc_pkg::RST_MAX_LIMIT;
      fast_thr = apsc_pkg::RST_FAST_THR;
      grow     = apsc_pkg::RST_GROW_FAC;
      slow_thr = apsc_pkg::RST_SLOW_THR;
      shrink   = apsc_pkg::RST_SHRINK;
      tmo      = apsc_pkg::RST_TIMEOUT;
      step     = apsc_pkg::RST_STEP;
      limit    = 24'd1;
      errors   = 0;
      compared = 0;
    endfunction

    function void write_reg(apsc_pkg::cfg_idx_e idx,
                            logic [apsc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        apsc_pkg::CFG_MIN_LIMIT: min_reg  = data[apsc_pkg::BOUND_W-1:0];
        apsc_pkg::CFG_MAX_LIMIT: max_reg  = data[apsc_pkg::BOUND_W-1:0];
        apsc_pkg::CFG_FAST_THR:  fast_thr = data[apsc_pkg::THR_W-1:0];
        apsc_pkg::CFG_GROW_FAC:  grow     = data[apsc_pkg::FACTOR_W-1:0];
        apsc_pkg::CFG_SLOW_THR:  slow_thr = data[apsc_pkg::THR_W-1:0];
        apsc_pkg::CFG_SHRINK:    shrink   = data[apsc_pkg::FRAC_W-1:0];
        apsc_pkg::CFG_TIMEOUT:   tmo      = data[apsc_pkg::FRAC_W-1:0];
        apsc_pkg::CFG_STEP:      step     = data[apsc_pkg::STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] bound_of(logic [63:0] r);
      logic [63:0] v;
      v = r;
      if (v < 64'd1) v = 64'd1;
      if (v > LIMIT_MAX) v = LIMIT_MAX;
      return v;
    endfunction

    function logic [63:0] clamp(logic [63:0] v);
      logic [63:0] lo;
      logic [63:0] hi;
      lo = bound_of({40'd0, min_reg});
      hi = bound_of({40'd0, max_reg});
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
    endfunction

    // Clamp, then, for a step above one, round to the nearest multiple of the step and clamp once more.
    function void settle(logic [63:0] v);
      logic [63:0] s;
      logic [63:0] q;
      s = {48'd0, step};
      v = clamp(v);
      if (s > 64'd1) begin
        q = (v + s / 64'd2) / s;
        v = q * s;
        if (v < 64'd1) v = 64'd1;
        v = clamp(v);
      end
      limit = v[apsc_pkg::PAGE_W-1:0];
    endfunction

    function void scale(apsc_pkg::factor_t factor);
      logic [63:0] p;
      p = ({40'd0, limit} * {48'd0, factor}) >> apsc_pkg::FRAC_W;
      if (p > LIMIT_MAX) p = LIMIT_MAX;
      settle(p);
    endfunction

    function void note_item(logic [apsc_pkg::OP_W-1:0] op,
                            logic [apsc_pkg::DUR_W-1:0] dur,
                            logic [apsc_pkg::BOUND_W-1:0] start);
      case (op)
        apsc_pkg::OP_SUCCESS: begin
          // a negative duration falls in neither band
          if (!dur[apsc_pkg::DUR_W-1] && dur[apsc_pkg::THR_W-1:0] < fast_thr) scale(grow);
          else if (!dur[apsc_pkg::DUR_W-1] && dur[apsc_pkg::THR_W-1:0] > slow_thr)
            scale({8'd0, shrink});
        end
        apsc_pkg::OP_TIMEOUT: scale({8'd0, tmo});
        apsc_pkg::OP_RESTART: settle({40'd0, start});
        default: ;
      endcase
      owed_q.push_back(limit);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    function int unsigned pending();
      return owed_q.size();
    endfunction

    task check_result(apsc_pkg::page_t got);
      apsc_pkg::page_t want;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("page_limit %0d with no item outstanding", got));
      end else begin
        want = owed_q.pop_front();
        compared++;
        if (got !== want)
          report_mismatch($sformatf("page_limit %0d, predicted %0d", got, want));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [apsc_pkg::OP_W-1:0] operation = apsc_pkg::OP_SUCCESS;
  logic signed [apsc_pkg::DUR_W-1:0] duration_ms = '0;
  logic [apsc_pkg::BOUND_W-1:0] start_limit = '0;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [apsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [apsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_stall;
  logic out_valid;
  apsc_pkg::page_t page_limit;

  int unsigned idle_pct = 8;
  int unsigned stall_pct = 8;
  int unsigned items_sent = 0;
  int unsigned settings = 1;

  page_limit_scoreboard sb = new();

  adaptive_page_size_controller_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .duration_ms_i (duration_ms),
    .start_limit_i (start_limit),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .page_limit_o  (page_limit),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(operation, duration_ms, start_limit);
      if (out_valid && !out_stall) sb.check_result(page_limit);
    end
  end

  task automatic set_reg(apsc_pkg::cfg_idx_e idx, logic [apsc_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold the item until it is taken; leave valid high for a back-to-back follower.
  task automatic send_item(logic [apsc_pkg::OP_W-1:0] op, logic [apsc_pkg::DUR_W-1:0] dur,
                           logic [apsc_pkg::BOUND_W-1:0] start);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    duration_ms <= dur;
    start_limit <= start;
    items_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic [apsc_pkg::CFG_DATA_W-1:0] junk_top(
      logic [apsc_pkg::BOUND_W-1:0] v);
    logic [6:0] top;
    top = 7'($urandom_range(127));
    return {top, v};
  endfunction

  task automatic random_config();
    logic [apsc_pkg::BOUND_W-1:0] mn;
    logic [apsc_pkg::BOUND_W-1:0] mx;
    logic [apsc_pkg::THR_W-1:0] ft;
    logic [apsc_pkg::THR_W-1:0] st;
    logic [31:0] wide;
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) mn = '0;
    else if (r == 1) mn = 24'hFFFFFF;
    else if (r < 6) mn = 24'($urandom_range(1, 64));
    else mn = 24'($urandom_range(1, 5000));
    r = $urandom_range(9);
    if (r == 0) mx = '0;
    else if (r < 3) mx = 24'hFFFFFF;
    else if (r < 6) mx = 24'($urandom_range(1000, 200000));
    else if (r < 9) mx = 24'($urandom);
    else mx = 24'($urandom_range(1, 50));
    r = $urandom_range(9);
    if (r == 0) ft = '0;
    else if (r == 1) ft = 31'h7FFFFFFF;
    else if (r == 2) ft = 31'($urandom);
    else ft = 31'($urandom_range(1, 3000));
    r = $urandom_range(9);
    wide = {1'b0, ft} + $urandom_range(0, 5000);
    if (r == 0) st = '0;
    else if (r == 1) st = 31'($urandom);
    else if (wide[31]) st = 31'h7FFFFFFF;
    else st = wide[apsc_pkg::THR_W-1:0];
    set_reg(apsc_pkg::CFG_MIN_LIMIT, junk_top(mn));
    set_reg(apsc_pkg::CFG_MAX_LIMIT, junk_top(mx));
    set_reg(apsc_pkg::CFG_FAST_THR, ft);
    set_reg(apsc_pkg::CFG_SLOW_THR, st);
    r = $urandom_range(9);
    if (r == 0) set_reg(apsc_pkg::CFG_GROW_FAC, 31'd0);
    else if (r == 1) set_reg(apsc_pkg::CFG_GROW_FAC, 31'd65535);
    else if (r == 2) set_reg(apsc_pkg::CFG_GROW_FAC, 31'($urandom));
    else set_reg(apsc_pkg::CFG_GROW_FAC, 31'($urandom_range(256, 1024)));
    r = $urandom_range(9);
    if (r == 0) set_reg(apsc_pkg::CFG_SHRINK, {15'd0, 8'($urandom_range(255)), 8'd0});
    else set_reg(apsc_pkg::CFG_SHRINK, 31'($urandom_range(1, 255)));
    r = $urandom_range(9);
    if (r == 0) set_reg(apsc_pkg::CFG_TIMEOUT, 31'd255);
    else set_reg(apsc_pkg::CFG_TIMEOUT, 31'($urandom));
    r = $urandom_range(9);
    if (r < 5) set_reg(apsc_pkg::CFG_STEP, 31'd1);
    else if (r == 5) set_reg(apsc_pkg::CFG_STEP, 31'd0);
    else if (r == 6) set_reg(apsc_pkg::CFG_STEP, 31'd65535);
    else if (r == 7) set_reg(apsc_pkg::CFG_STEP, 31'($urandom));
    else set_reg(apsc_pkg::CFG_STEP, 31'($urandom_range(2, 16)));
    settings++;
  endtask

  // Favour durations on and around the band edges.
  function automatic logic [apsc_pkg::DUR_W-1:0] pick_duration();
    logic [31:0] d;
    int unsigned r;
    r = $urandom_range(9);
    if (r < 2) d = $urandom;
    else if (r < 5) d = (sb.fast_thr == 0) ? 32'd0 : $urandom_range(0, sb.fast_thr - 1);
    else if (r < 7) begin
      d = {1'b0, sb.slow_thr} + 32'd1 + $urandom_range(0, 1000);
      if (d[31]) d = 32'h7FFFFFFF;
    end else if (r == 7) begin
      case ($urandom_range(3))
        0: d = {1'b0, sb.fast_thr};
        1: d = {1'b0, sb.slow_thr};
        2: d = {1'b0, sb.fast_thr} - 32'd1;
        default: d = {1'b0, sb.slow_thr} + 32'd1;
      endcase
      if (d[31]) d = {1'b0, sb.slow_thr};
    end else if (r == 8) d = {1'b0, sb.fast_thr} + $urandom_range(0, 4000);
    else d = {1'b1, 31'($urandom)};
    return d;
  endfunction

  function automatic logic [apsc_pkg::BOUND_W-1:0] pick_start();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) return 24'($urandom);
    if (r < 8) return 24'($urandom_range(0, 5000));
    if (r == 8) return sb.min_reg;
    return sb.max_reg;
  endfunction

  initial begin
    int unsigned r;
    logic [apsc_pkg::OP_W-1:0] op;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: band edges, negative durations, saturation, unused code
    send_item(apsc_pkg::OP_SUCCESS, 32'd0, 24'd0);
    send_item(apsc_pkg::OP_SUCCESS, 32'd999, 24'hFFFFFF);
    send_item(apsc_pkg::OP_SUCCESS, 32'd1000, 24'd0);
    send_item(apsc_pkg::OP_SUCCESS, 32'd5000, 24'd0);
    send_item(apsc_pkg::OP_SUCCESS, 32'd5001, 24'd0);
    send_item(apsc_pkg::OP_SUCCESS, 32'hFFFFFFFF, 24'd0);
    send_item(apsc_pkg::OP_SUCCESS, 32'h80000000, 24'd0);
    send_item(apsc_pkg::OP_SUCCESS, 32'h7FFFFFFF, 24'd0);
    send_item(apsc_pkg::OP_TIMEOUT, 32'hFFFFFFFF, 24'hFFFFFF);
    send_item(apsc_pkg::OP_RESTART, 32'd0, 24'd0);
    send_item(apsc_pkg::OP_RESTART, 32'd0, 24'hFFFFFF);
    send_item(apsc_pkg::OP_SUCCESS, 32'd0, 24'd0);
    send_item(OP_UNUSED, 32'd0, 24'd77);
    drain();

    // zero bounds read as one, no rounding with a zero step
    set_reg(apsc_pkg::CFG_MIN_LIMIT, 31'd0);
    set_reg(apsc_pkg::CFG_MAX_LIMIT, 31'h7F000000);
    set_reg(apsc_pkg::CFG_STEP, 31'd0);
    set_reg(apsc_pkg::CFG_GROW_FAC, 31'd65535);
    set_reg(apsc_pkg::CFG_FAST_THR, 31'd0);
    set_reg(apsc_pkg::CFG_SLOW_THR, 31'h7FFFFFFF);
    settings++;
    send_item(apsc_pkg::OP_RESTART, 32'd0, 24'd12345);
    send_item(apsc_pkg::OP_SUCCESS, 32'd0, 24'd0);
    send_item(apsc_pkg::OP_TIMEOUT, 32'd0, 24'd0);
    drain();

    // maximum below minimum, zero factors
    set_reg(apsc_pkg::CFG_MIN_LIMIT, 31'd1000);
    set_reg(apsc_pkg::CFG_MAX_LIMIT, 31'd500);
    set_reg(apsc_pkg::CFG_GROW_FAC, 31'd0);
    set_reg(apsc_pkg::CFG_SHRINK, 31'd0);
    set_reg(apsc_pkg::CFG_TIMEOUT, 31'd0);
    set_reg(apsc_pkg::CFG_STEP, 31'd7);
    set_reg(apsc_pkg::CFG_FAST_THR, 31'h7FFFFFFF);
    set_reg(apsc_pkg::CFG_SLOW_THR, 31'd0);
    settings++;
    send_item(apsc_pkg::OP_RESTART, 32'd0, 24'd10);
    send_item(apsc_pkg::OP_SUCCESS, 32'd100, 24'd0);
    send_item(apsc_pkg::OP_SUCCESS, 32'h7FFFFFFF, 24'd0);
    send_item(apsc_pkg::OP_TIMEOUT, 32'd0, 24'd0);
    drain();

    // rounding to zero raised to one
    set_reg(apsc_pkg::CFG_MIN_LIMIT, 31'd1);
    set_reg(apsc_pkg::CFG_MAX_LIMIT, 31'd100);
    set_reg(apsc_pkg::CFG_STEP, 31'd65535);
    set_reg(apsc_pkg::CFG_GROW_FAC, 31'd512);
    set_reg(apsc_pkg::CFG_SHRINK, 31'd255);
    set_reg(apsc_pkg::CFG_TIMEOUT, 31'd255);
    set_reg(apsc_pkg::CFG_FAST_THR, 31'd1000);
    set_reg(apsc_pkg::CFG_SLOW_THR, 31'd5000);
    settings++;
    send_item(apsc_pkg::OP_RESTART, 32'd0, 24'd60);
    send_item(apsc_pkg::OP_RESTART, 32'd0, 24'hFFFFFF);
    send_item(apsc_pkg::OP_SUCCESS, 32'd0, 24'd0);
    drain();

    // both bounds at the top
    set_reg(apsc_pkg::CFG_MIN_LIMIT, 31'hFFFFFF);
    set_reg(apsc_pkg::CFG_MAX_LIMIT, 31'hFFFFFF);
    settings++;
    send_item(apsc_pkg::OP_RESTART, 32'd0, 24'd0);
    send_item(apsc_pkg::OP_TIMEOUT, 32'd0, 24'd0);
    drain();

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      random_config();
      // a quiet stretch with no idling on either side
      idle_pct  = (ph == 4 || ph == 5) ? 0 : 8;
      stall_pct = idle_pct;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 55) op = apsc_pkg::OP_SUCCESS;
        else if (r < 75) op = apsc_pkg::OP_TIMEOUT;
        else if (r < 94) op = apsc_pkg::OP_RESTART;
        else op = OP_UNUSED;
        send_item(op, pick_duration(), pick_start());
      end
      drain();
    end

    $display("Run sent %0d items under %0d register settings; %0d page limits compared.",
             items_sent, settings, sb.compared);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("adaptive_page_size_controller_top verification clean");
    end else begin
      $display("adaptive_page_size_controller_top verification failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Run timed out with %0d page limits still owed.", sb.pending());
    $display("adaptive_page_size_controller_top verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/apsc_pkg.sv
design/apsc_mul.sv
design/apsc_div.sv
design/adaptive_page_size_controller_top.sv
dv/tb_adaptive_page_size_controller_top.sv
